// ===== rtl/core/dpac_pkg.sv =====
package dpac_pkg;

   localparam int NumChars   = 16;
   localparam int SymWidth   = 5;
   localparam int CharWidth  = 4;
   localparam int LenWidth   = 5;
   localparam int MaxSymbols = 16;

   localparam logic [SymWidth-1:0]  SymLitMax = 5'd14;
   localparam logic [SymWidth-1:0]  SymX      = 5'd15;
   localparam logic [SymWidth-1:0]  SymZ      = 5'd16;
   localparam logic [SymWidth-1:0]  SymN      = 5'd17;
   localparam logic [SymWidth-1:0]  SymDot    = 5'd18;
   localparam logic [CharWidth-1:0] CharOther = 4'd15;
   localparam logic [CharWidth-1:0] DigitMax  = 4'd9;
   localparam logic [CharWidth-1:0] ZMin      = 4'd1;
   localparam logic [CharWidth-1:0] NMin      = 4'd2;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_CHECK  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [LenWidth-1:0] len;
      logic                is_pattern;
      logic                deny;
      logic [39:0]         sym_high;
      logic [39:0]         sym_low;
   } entry_type;

   typedef struct packed {
      logic do_clear;
      logic do_append;
      logic load_imm;
      logic start_check;
      logic scan;
      logic load_chk;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic count_zero;
      logic cmp_hit;
      logic cmp_last;
   } dp_status_type;

   // one pattern symbol against one character (dot handled by the caller)
   function automatic logic sym_ok(input logic [SymWidth-1:0] sym,
                                   input logic [CharWidth-1:0] chr);
      logic ok;
      if (sym <= SymLitMax) begin
         ok = (sym[CharWidth-1:0] == chr);
      end else begin
         case (sym)
            SymX:    ok = (chr <= DigitMax);
            SymZ:    ok = (chr >= ZMin) && (chr <= DigitMax);
            SymN:    ok = (chr >= NMin) && (chr <= DigitMax);
            default: ok = 1'b1;
         endcase
      end
      return ok;
   endfunction

endpackage

// ===== rtl/core/dpac_match.sv =====
module dpac_match (
   input  dpac_pkg::entry_type          entry,
   input  logic [63:0]                  digits,
   input  logic [dpac_pkg::LenWidth-1:0] num_len,
   output logic                         hit
);
   import dpac_pkg::*;

   logic [2*40-1:0]       all_syms;
   logic [SymWidth-1:0]   sym_k;
   logic [CharWidth-1:0]  chr_k;
   logic [NumChars-1:0]   in_len;
   logic [NumChars-1:0]   in_num;
   logic [NumChars-1:0]   is_dot;
   logic [NumChars-1:0]   dot_incl;
   logic [NumChars-1:0]   active;
   logic [NumChars-1:0]   sym_good;
   logic [NumChars-1:0]   pre_good;
   logic [NumChars-1:0]   tail_bad;
   logic                  dot_before;

   assign all_syms = {entry.sym_high, entry.sym_low};

   always_comb begin
      dot_before = 1'b0;
      sym_k      = '0;
      chr_k      = '0;
      for (int k = 0; k < NumChars; k++) begin
         sym_k       = all_syms[SymWidth*k +: SymWidth];
         chr_k       = digits[CharWidth*k +: CharWidth];
         in_len[k]   = LenWidth'(k) < entry.len;
         in_num[k]   = LenWidth'(k) < num_len;
         is_dot[k]   = in_len[k] && (sym_k == SymDot);
         // symbols at and after the first dot are not compared one by one
         active[k]   = in_len[k] && !dot_before && !is_dot[k];
         dot_incl[k] = dot_before || is_dot[k];
         dot_before  = dot_incl[k];
         sym_good[k] = !active[k] || (in_num[k] && sym_ok(sym_k, chr_k));
         pre_good[k] = !in_len[k] || ((sym_k == {1'b0, chr_k}) && (chr_k != CharOther));
         // characters swallowed by the dot must be digits or A-E
         tail_bad[k] = in_num[k] && dot_incl[k] && (chr_k == CharOther);
      end
   end

   always_comb begin
      if (entry.is_pattern) begin
         hit = (&sym_good) && !(|tail_bad) &&
               (dot_incl[NumChars-1] || (entry.len == num_len));
      end else begin
         hit = (&pre_good) && (entry.len <= num_len);
      end
   end

endmodule

// ===== rtl/core/dpac_ctrl.sv =====
module dpac_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_opcode,
   output logic                    req_ready,
   input  dpac_pkg::dp_status_type sts,
   output dpac_pkg::ctrl_cmd_type  cmd
);
   import dpac_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   opcode_type op;

   assign op = opcode_type'(req_opcode);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = sts.rsp_free;
            if (req_valid && sts.rsp_free) begin
               case (op)
                  OP_CLEAR: begin
                     cmd.do_clear = 1'b1;
                     cmd.load_imm = 1'b1;
                  end
                  OP_APPEND: begin
                     cmd.do_append = 1'b1;
                     cmd.load_imm  = 1'b1;
                  end
                  OP_CHECK: begin
                     cmd.start_check = 1'b1;
                     state_in = sts.count_zero ? ST_FINISH : ST_SCAN;
                  end
                  default: begin
                     cmd.load_imm = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.cmp_hit || sts.cmp_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_chk = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/dpac_datapath.sv =====
module dpac_datapath #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_entry_deny,
   input  logic                          req_entry_is_pattern,
   input  logic [4:0]                    req_entry_length,
   input  logic [39:0]                   req_symbols_low,
   input  logic [39:0]                   req_symbols_high,
   input  logic [63:0]                   req_number_digits,
   input  logic [4:0]                    req_number_length,
   input  dpac_pkg::ctrl_cmd_type        cmd,
   output dpac_pkg::dp_status_type       sts,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_permit,
   output logic                          rsp_matched,
   output logic [3:0]                    rsp_match_index,
   output logic                          rsp_status
);
   import dpac_pkg::*;

   localparam int CountWidth = $clog2(MAX_ENTRIES + 1);
   localparam int IndexWidth = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   entry_type             mem [MAX_ENTRIES];
   entry_type             wr_entry;
   entry_type             rd_data_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] rd_idx_ff;
   logic [CountWidth-1:0] rd_tag_ff;
   logic                  rd_vld_ff;
   logic                  read_en;
   logic                  full;
   logic [LenWidth-1:0]   len_sat;
   logic [LenWidth-1:0]   num_sat;
   logic [63:0]           digits_ff;
   logic [LenWidth-1:0]   nlen_ff;
   logic                  match_hit;
   logic                  found_ff;
   logic                  found_permit_ff;
   logic [3:0]            found_idx_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_permit_ff;
   logic                  rsp_matched_ff;
   logic [3:0]            rsp_idx_ff;
   logic                  rsp_status_ff;

   assign full    = (count_ff == CountWidth'(MAX_ENTRIES));
   assign len_sat = (req_entry_length > LenWidth'(MaxSymbols)) ?
                    LenWidth'(MaxSymbols) : req_entry_length;
   assign num_sat = (req_number_length > LenWidth'(NumChars)) ?
                    LenWidth'(NumChars) : req_number_length;
   assign read_en = cmd.scan && (rd_idx_ff < count_ff);

   always_comb begin
      wr_entry.len        = len_sat;
      wr_entry.is_pattern = req_entry_is_pattern;
      wr_entry.deny       = req_entry_deny;
      wr_entry.sym_high   = req_symbols_high;
      wr_entry.sym_low    = req_symbols_low;
   end

   // entry table
   always_ff @(posedge clock) begin
      if (cmd.do_append && !full) begin
         mem[count_ff[IndexWidth-1:0]] <= wr_entry;
      end
      rd_data_ff <= mem[rd_idx_ff[IndexWidth-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_clear) begin
         count_ff <= '0;
      end else if (cmd.do_append && !full) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // scan address and compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= read_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_check) begin
         rd_idx_ff <= '0;
         digits_ff <= req_number_digits;
         nlen_ff   <= num_sat;
      end else if (read_en) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
      rd_tag_ff <= rd_idx_ff;
   end

   dpac_match u_match (
      .entry   (rd_data_ff),
      .digits  (digits_ff),
      .num_len (nlen_ff),
      .hit     (match_hit)
   );

   always_comb begin
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
      sts.count_zero = (count_ff == '0);
      sts.cmp_hit    = rd_vld_ff && match_hit;
      sts.cmp_last   = rd_vld_ff && (rd_tag_ff == count_ff - 1'b1);
   end

   // first hit of the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.start_check) begin
         found_ff <= 1'b0;
      end else if (cmd.scan && sts.cmp_hit) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && sts.cmp_hit) begin
         found_permit_ff <= !rd_data_ff.deny;
         found_idx_ff    <= 4'(rd_tag_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_imm || cmd.load_chk) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_imm) begin
         rsp_permit_ff  <= 1'b0;
         rsp_matched_ff <= 1'b0;
         rsp_idx_ff     <= '0;
         rsp_status_ff  <= cmd.do_append && full;
      end else if (cmd.load_chk) begin
         rsp_permit_ff  <= found_ff && found_permit_ff;
         rsp_matched_ff <= found_ff;
         rsp_idx_ff     <= found_ff ? found_idx_ff : 4'd0;
         rsp_status_ff  <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_permit      = rsp_permit_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== rtl/core/dial_pattern_acl_check.sv =====
// Ordered access list for telephone numbers, up to MAX_ENTRIES permit or deny
// entries, each a literal prefix or a dial pattern (literal, X, Z, N, any and a
// trailing dot). Every request transaction gives exactly one response
// transaction. Clear and append present their response in the cycle after acceptance;
// an append on a full table is refused with status set. A check walks the
// entries in order through the single read port of the entry memory, one entry
// compared per cycle with all sixteen symbol positions in parallel, and stops at
// the first hit; no further request is accepted until it has finished. Requests
// are taken one at a time, and only while the output register is empty or hands
// its response off in the same cycle.
module dial_pattern_acl_check #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic        req_entry_deny,
   input  logic        req_entry_is_pattern,
   input  logic [4:0]  req_entry_length,
   input  logic [39:0] req_symbols_low,
   input  logic [39:0] req_symbols_high,
   input  logic [63:0] req_number_digits,
   input  logic [4:0]  req_number_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_permit,
   output logic        rsp_matched,
   output logic [3:0]  rsp_match_index,
   output logic        rsp_status
);
   import dpac_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   dpac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dpac_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_entry_deny       (req_entry_deny),
      .req_entry_is_pattern (req_entry_is_pattern),
      .req_entry_length     (req_entry_length),
      .req_symbols_low      (req_symbols_low),
      .req_symbols_high     (req_symbols_high),
      .req_number_digits    (req_number_digits),
      .req_number_length    (req_number_length),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_permit           (rsp_permit),
      .rsp_matched          (rsp_matched),
      .rsp_match_index      (rsp_match_index),
      .rsp_status           (rsp_status)
   );

endmodule

// ===== verif/acl_verdict_checker.sv =====
module acl_verdict_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic        req_entry_deny,
   input  logic        req_entry_is_pattern,
   input  logic [4:0]  req_entry_length,
   input  logic [39:0] req_symbols_low,
   input  logic [39:0] req_symbols_high,
   input  logic [63:0] req_number_digits,
   input  logic [4:0]  req_number_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_permit,
   input  logic        rsp_matched,
   input  logic [3:0]  rsp_match_index,
   input  logic        rsp_status,
   output int          error_count,
   output int          pending_count
);
   import dpac_pkg::*;

   typedef struct packed {
      logic       permit;
      logic       matched;
      logic [3:0] match_index;
      logic       status;
   } verdict_type;

   entry_type   acl_table [MAX_ENTRIES];
   int          table_fill;
   verdict_type expected_verdicts [$];

   function automatic logic char_fits(input logic [4:0] sym, input logic [3:0] chr);
      case (sym)
         SymX:    return chr <= DigitMax;
         SymZ:    return (chr >= ZMin) && (chr <= DigitMax);
         SymN:    return (chr >= NMin) && (chr <= DigitMax);
         default: return (sym > SymLitMax) || (sym == {1'b0, chr});
      endcase
   endfunction

   function automatic bit prefix_fits(input entry_type ent, input logic [63:0] digits,
                                      input int n);
      logic [79:0] syms;
      logic [4:0]  s;
      int          k;
      syms = {ent.sym_high, ent.sym_low};
      if (int'(ent.len) > n) return 1'b0;
      for (k = 0; k < int'(ent.len); k++) begin
         s = syms[5*k +: 5];
         if (s > SymLitMax || s != {1'b0, digits[4*k +: 4]}) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit pattern_fits(input entry_type ent, input logic [63:0] digits,
                                       input int n);
      logic [79:0] syms;
      logic [4:0]  s;
      logic [3:0]  c;
      int          len;
      int          i;
      int          j;
      syms = {ent.sym_high, ent.sym_low};
      len = ent.len;
      i = 0;
      j = 0;
      forever begin
         s = (i < 16) ? syms[5*i +: 5] : 5'd0;
         if (i == len && j == n) return 1'b1;
         // a dot swallows whatever is left, nothing included
         if (i < len && s == SymDot && j == n) return 1'b1;
         if (i == len || j == n) return 1'b0;
         c = digits[4*j +: 4];
         if (s == SymDot) begin
            if (c == CharOther) return 1'b0;
            j++;
         end else if (char_fits(s, c)) begin
            i++;
            j++;
         end else begin
            return 1'b0;
         end
      end
   endfunction

   function automatic verdict_type predict_verdict(
      input logic [1:0]  op,
      input logic        deny,
      input logic        is_pattern,
      input logic [4:0]  entry_len,
      input logic [39:0] sym_low,
      input logic [39:0] sym_high,
      input logic [63:0] digits,
      input logic [4:0]  number_len
   );
      verdict_type v;
      int          n;
      int          e;
      bit          hit;
      v = '0;
      case (opcode_type'(op))
         OP_CLEAR: table_fill = 0;
         OP_APPEND: begin
            if (table_fill >= MAX_ENTRIES) begin
               v.status = 1'b1;
            end else begin
               acl_table[table_fill].len        = (entry_len > MaxSymbols) ?
                                                  5'(MaxSymbols) : entry_len;
               acl_table[table_fill].is_pattern = is_pattern;
               acl_table[table_fill].deny       = deny;
               acl_table[table_fill].sym_low    = sym_low;
               acl_table[table_fill].sym_high   = sym_high;
               table_fill++;
            end
         end
         OP_CHECK: begin
            n = (number_len > NumChars) ? NumChars : int'(number_len);
            for (e = 0; e < table_fill; e++) begin
               hit = acl_table[e].is_pattern ? pattern_fits(acl_table[e], digits, n)
                                             : prefix_fits(acl_table[e], digits, n);
               if (hit) begin
                  v.permit      = ~acl_table[e].deny;
                  v.matched     = 1'b1;
                  v.match_index = e[3:0];
                  break;
               end
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic compare_field(input string what, input logic [3:0] want,
                                input logic [3:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         table_fill = 0;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               error_count++;
               $display("%0t: response transaction with none expected, actual %0h/%0h/%0h/%0h",
                        $time, rsp_permit, rsp_matched, rsp_match_index, rsp_status);
            end else begin
               want = expected_verdicts.pop_front();
               compare_field("permit", want.permit, rsp_permit);
               compare_field("matched", want.matched, rsp_matched);
               compare_field("match_index", want.match_index, rsp_match_index);
               compare_field("status", want.status, rsp_status);
            end
         end
         if (req_valid && req_ready)
            expected_verdicts.push_back(predict_verdict(req_opcode, req_entry_deny,
               req_entry_is_pattern, req_entry_length, req_symbols_low, req_symbols_high,
               req_number_digits, req_number_length));
      end
      pending_count = expected_verdicts.size();
   end

endmodule

// ===== verif/dial_pattern_acl_check_test.sv =====
module dial_pattern_acl_check_test;
   import dpac_pkg::*;

   localparam logic [4:0] SymAny     = 5'd19;
   localparam int         ItemTarget = 1500;
   localparam int         HoldCycles = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic        req_entry_deny;
   logic        req_entry_is_pattern;
   logic [4:0]  req_entry_length;
   logic [39:0] req_symbols_low;
   logic [39:0] req_symbols_high;
   logic [63:0] req_number_digits;
   logic [4:0]  req_number_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_permit;
   logic        rsp_matched;
   logic [3:0]  rsp_match_index;
   logic        rsp_status;

   int error_count;
   int pending_count;
   int req_idle_pct;
   int rsp_idle_pct;
   int items_sent;
   bit hold_request;

   // entries the table should hold, used to aim checks at real hits
   logic [79:0] acl_syms [$];
   logic [4:0]  acl_len [$];
   bit          acl_pat [$];

   dial_pattern_acl_check #(.MAX_ENTRIES(16)) dut (.*);

   acl_verdict_checker #(.MAX_ENTRIES(16)) verdict_check (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("dial_pattern_acl_check_test: errors");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [39:0] rand40();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[39:0];
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [4:0] random_symbol(input bit pat);
      int pick;
      pick = $urandom_range(99);
      if (!pat) begin
         if (pick < 90) return 5'($urandom_range(9));
         if (pick < 96) return 5'($urandom_range(14, 10));
         return 5'($urandom_range(31, 15));
      end
      if (pick < 45) return 5'($urandom_range(9));
      if (pick < 52) return 5'($urandom_range(14, 10));
      if (pick < 64) return SymX;
      if (pick < 72) return SymZ;
      if (pick < 80) return SymN;
      if (pick < 88) return SymAny;
      if (pick < 94) return 5'($urandom_range(31, 20));
      return SymDot;
   endfunction

   // build a number that the entry should accept, then sometimes spoil it
   function automatic void make_hit(input logic [79:0] syms, input logic [4:0] len,
                                    input bit pat, output logic [63:0] digits,
                                    output logic [4:0] nlen);
      logic [4:0] s;
      int         eff;
      int         j;
      int         k;
      digits = rand64();
      eff = (len > 16) ? 16 : int'(len);
      j = 0;
      for (k = 0; k < eff; k++) begin
         s = syms[5*k +: 5];
         if (pat && s == SymDot) begin
            repeat ($urandom_range(16 - j)) begin
               digits[4*j +: 4] = 4'($urandom_range(14));
               j++;
            end
            break;
         end
         if (s <= SymLitMax)  digits[4*j +: 4] = s[3:0];
         else if (s == SymX)  digits[4*j +: 4] = 4'($urandom_range(9));
         else if (s == SymZ)  digits[4*j +: 4] = 4'($urandom_range(9, 1));
         else if (s == SymN)  digits[4*j +: 4] = 4'($urandom_range(9, 2));
         else                 digits[4*j +: 4] = 4'($urandom_range(15));
         j++;
      end
      if (!pat) j += $urandom_range(16 - j);
      nlen = 5'(j);
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(1)) digits[4*$urandom_range(15) +: 4] = 4'($urandom_range(15));
         else nlen = 5'($urandom_range(16));
      end
   endfunction

   task automatic send_request(input opcode_type op, input logic deny, input logic pat,
                               input logic [4:0] elen, input logic [39:0] lo,
                               input logic [39:0] hi, input logic [63:0] digits,
                               input logic [4:0] nlen);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid            <= 1'b1;
      req_opcode           <= op;
      req_entry_deny       <= deny;
      req_entry_is_pattern <= pat;
      req_entry_length     <= elen;
      req_symbols_low      <= lo;
      req_symbols_high     <= hi;
      req_number_digits    <= digits;
      req_number_length    <= nlen;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_noise(input opcode_type op);
      send_request(op, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   5'($urandom_range(31)), rand40(), rand40(), rand64(),
                   5'($urandom_range(31)));
   endtask

   task automatic append_random_entry();
      logic [95:0] noise;
      logic [79:0] syms;
      logic [4:0]  len;
      bit          pat;
      int          pick;
      int          k;
      int          eff;
      pat = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 80)      len = 5'($urandom_range(8, 1));
      else if (pick < 95) len = 5'($urandom_range(16, 9));
      else                len = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 17));
      noise = {$urandom, $urandom, $urandom};
      syms = noise[79:0];
      eff = (len > 16) ? 16 : int'(len);
      // now and then the symbols stay pure noise
      if ($urandom_range(19) != 0) begin
         for (k = 0; k < eff; k++) syms[5*k +: 5] = random_symbol(pat);
         if (pat && eff > 0 && $urandom_range(9) < 3) syms[5*(eff-1) +: 5] = SymDot;
      end
      send_request(OP_APPEND, 1'($urandom_range(1)), pat, len, syms[39:0], syms[79:40],
                   rand64(), 5'($urandom_range(31)));
      if (acl_syms.size() < 16) begin
         acl_syms.push_back(syms);
         acl_len.push_back(len);
         acl_pat.push_back(pat);
      end
   endtask

   task automatic check_random_number();
      logic [63:0] digits;
      logic [4:0]  nlen;
      int          e;
      if (acl_syms.size() > 0 && $urandom_range(3) != 0) begin
         e = $urandom_range(acl_syms.size() - 1);
         make_hit(acl_syms[e], acl_len[e], acl_pat[e], digits, nlen);
      end else begin
         digits = rand64();
         nlen = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
                                         : 5'($urandom_range(16));
      end
      send_request(OP_CHECK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   5'($urandom_range(31)), rand40(), rand40(), digits, nlen);
   endtask

   // one table build followed by a burst of checks
   task automatic run_session();
      int pick;
      int n_app;
      int k;
      if ($urandom_range(3) == 0 || (acl_syms.size() >= 16 && $urandom_range(1) == 0)) begin
         send_noise(OP_CLEAR);
         acl_syms.delete();
         acl_len.delete();
         acl_pat.delete();
      end
      pick = $urandom_range(99);
      if (pick < 70)      n_app = $urandom_range(5, 1);
      else if (pick < 90) n_app = $urandom_range(12, 6);
      else                n_app = $urandom_range(20, 13);
      repeat (n_app) append_random_entry();
      for (k = $urandom_range(10, 2); k > 0; k--) begin
         if ($urandom_range(19) == 0) send_noise(OP_NONE);
         else check_random_number();
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_opcode           = OP_CLEAR;
      req_entry_deny       = 1'b0;
      req_entry_is_pattern = 1'b0;
      req_entry_length     = '0;
      req_symbols_low      = '0;
      req_symbols_high     = '0;
      req_number_digits    = '0;
      req_number_length    = '0;
      req_idle_pct         = 13;
      rsp_idle_pct         = 73;
      items_sent           = 0;
      hold_request         = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // unused opcode, then default deny on an empty table with an overlong number
      send_request(OP_NONE, 1'b1, 1'b1, 5'h1f, '1, '1, '1, 5'h1f);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h0123456789abcdef, 5'd31);
      // prefix holding an X never matches; overlong all-X pattern; empty pattern
      send_request(OP_APPEND, 1'b1, 1'b0, 5'd3, {25'd0, 5'd1, SymX, 5'd9}, '0, '0, '0);
      send_request(OP_APPEND, 1'b0, 1'b1, 5'd31, {8{SymX}}, {8{SymX}}, '0, '0);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h1234567890123159, 5'd16);
      send_request(OP_APPEND, 1'b1, 1'b1, 5'd0, '1, '1, '0, '0);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h1234567890123159, 5'd0);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h000000000000000a, 5'd16);
      send_request(OP_CLEAR, 1'b0, 1'b0, 5'd0, '0, '0, '0, '0);
      // N Z X then a trailing dot with junk behind it
      send_request(OP_APPEND, 1'b0, 1'b1, 5'd6,
                   {10'd0, 5'd31, 5'd7, SymDot, SymX, SymZ, SymN}, '0, '0, '0);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h012, 5'd3);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'hba012, 5'd5);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'hf012, 5'd4);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h011, 5'd3);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h002, 5'd3);
      // any, an unknown code acting as any, then a literal E
      send_request(OP_APPEND, 1'b1, 1'b1, 5'd3, {25'd0, 5'd14, 5'd25, SymAny}, '0, '0, '0);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'heff, 5'd3);
      // prefix longer than the number
      send_request(OP_APPEND, 1'b0, 1'b0, 5'd16, {8{5'd3}}, {8{5'd3}}, '0, '0);
      send_request(OP_CHECK, 1'b0, 1'b0, 5'd0, '0, '0, 64'h3f333, 5'd5);
      send_request(OP_CLEAR, 1'b0, 1'b0, 5'd0, '0, '0, '0, '0);

      while (items_sent < ItemTarget + 20) begin
         if (items_sent < 520) begin
            req_idle_pct = 13;
            rsp_idle_pct = 73;
         end else if (items_sent < 1020) begin
            req_idle_pct = 73;
            rsp_idle_pct = 13;
         end else begin
            // long receiver hold-off once, as the no-idle stretch begins
            if (req_idle_pct != 0) hold_request = 1'b1;
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_session();
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (25) @(posedge clock);
      if (error_count == 0)
         $display("dial_pattern_acl_check_test: clean");
      else
         $display("dial_pattern_acl_check_test: errors");
      $finish;
   end

endmodule

// ===== dial_pattern_acl_check.f =====
rtl/core/dpac_pkg.sv
rtl/core/dpac_match.sv
rtl/core/dpac_ctrl.sv
rtl/core/dpac_datapath.sv
rtl/core/dial_pattern_acl_check.sv
verif/acl_verdict_checker.sv
verif/dial_pattern_acl_check_test.sv
